[rtl/core/bfpa_pkg.sv]
// Shared types and constants of the best-fit partition allocator.
package bfpa_pkg;

	localparam int unsigned MEM_UNITS = 1024;
	localparam int unsigned ADDR_W    = 10;
	localparam int unsigned LEN_W     = 11;
	localparam int unsigned ID_W      = 8;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOFIT    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OSCAN,
		S_FSCAN,
		S_COMMIT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  len;
	} free_ent_t;

	typedef struct packed {
		logic [ID_W-1:0]   tag;
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  len;
	} owner_ent_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  len;
	} result_t;

endpackage

[rtl/core/best_fit_partition_allocator_unit.sv]
// Best-fit partition allocator with address-ordered coalescing of freed blocks.
//
// Requests arrive on the s_ channel: s_tuser is the mode (0 allocate, 1 free
// by owner id), s_tdata carries the owner id and the requested size. Each
// request gives exactly one result transaction on the m_ channel: a status,
// the start address and the size of the block granted or released.
// The free table and the owner table each live in a synchronous memory with
// a registered read; their valid bits are flip-flops. A request first scans
// the owner table, then, unless it ends early, the free table, then writes
// back in the commit state and hands the result to the output register from
// the response state. Both table scans read one entry per cycle. One request
// is in progress at a time; a new one is accepted while the previous result
// still waits in the output register.
// Reset leaves one free block covering the whole pool and no owners; no
// clearing pass is needed. While the receiver stalls, the result holds on
// m_tdata and a finished request waits before its result is loaded.
module best_fit_partition_allocator_unit #(
	parameter int unsigned OWNER_SLOTS = 32,
	parameter int unsigned FREE_SLOTS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [7:0] owner_id, [18:8] req_size, rest zero
	input  logic        s_tuser,  // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // [1:0] status, [11:2] start_addr, [22:12] block_size
);
	import bfpa_pkg::*;

	localparam int unsigned OIW = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
	localparam int unsigned FIW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int unsigned CW  = ((OIW > FIW) ? OIW : FIW) + 1;
	localparam logic [CW-1:0] OLIM = CW'(OWNER_SLOTS);
	localparam logic [CW-1:0] FLIM = CW'(FREE_SLOTS);

	// Memories and their valid bits.
	free_ent_t  fmem [FREE_SLOTS];
	owner_ent_t omem [OWNER_SLOTS];
	free_ent_t  frd_q;
	owner_ent_t ord_q;
	logic [FREE_SLOTS-1:0]  fvalid_q;
	logic [OWNER_SLOTS-1:0] ovalid_q;
	logic                   f0_init_q;

	// Request and scan state.
	state_t state_q, state_d;
	mode_t             mode_q;
	logic [ID_W-1:0]   id_q;
	logic [LEN_W-1:0]  size_q;
	logic [CW-1:0]     cnt_q;
	logic              v_s1;
	logic [CW-2:0]     idx_s1;

	// Owner scan results.
	logic              own_found_q;
	logic [OIW-1:0]    own_q;
	logic [ADDR_W-1:0] own_start_q;
	logic [LEN_W-1:0]  own_len_q;

	// Free scan results.
	logic              best_found_q, lo_found_q, hi_found_q, spare_found_q;
	logic [FIW-1:0]    best_q, lo_q, hi_q, spare_q;
	logic [ADDR_W-1:0] best_start_q, lo_start_q;
	logic [LEN_W-1:0]  best_len_q, lo_len_q, hi_len_q;

	result_t res_q, res_d;
	result_t out_q;
	logic    out_valid_q;

	// Combinational controls.
	logic       fwe, owe, fset, fclr, oclr;
	logic [FIW-1:0] fwa, fclr_a;
	logic [OIW-1:0] owa;
	free_ent_t  fwd;
	owner_ent_t owd;
	logic       scan_done;
	logic [CW-1:0] lim;
	free_ent_t  fent;
	logic [LEN_W:0] end_s1;
	logic [LEN_W-1:0] own_end;

	assign lim       = (state_q == S_OSCAN) ? OLIM : FLIM;
	assign scan_done = (cnt_q == lim) && !v_s1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {1'b0, out_q.len, out_q.start, out_q.status};

	// Entry 0 of the free table reads as the whole pool until first written.
	always_comb begin
		if (f0_init_q && (idx_s1[FIW-1:0] == '0)) begin
			fent.start = '0;
			fent.len   = LEN_W'(MEM_UNITS);
		end else begin
			fent = frd_q;
		end
	end
	assign end_s1  = {2'b00, fent.start} + {1'b0, fent.len};
	assign own_end = {1'b0, own_start_q} + own_len_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (s_tvalid) state_d = S_OSCAN;
			S_OSCAN: begin
				if (scan_done) begin
					if (mode_q == MODE_ALLOC) begin
						state_d = (own_found_q && size_q != '0) ? S_FSCAN : S_RESP;
					end else begin
						state_d = own_found_q ? S_FSCAN : S_RESP;
					end
				end
			end
			S_FSCAN:  if (scan_done) state_d = S_COMMIT;
			S_COMMIT: state_d = S_RESP;
			S_RESP:   if (!out_valid_q || m_tready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Write-back and result of a request.
	always_comb begin
		fwe = 1'b0; owe = 1'b0; fset = 1'b0; fclr = 1'b0; oclr = 1'b0;
		fwa = best_q; fclr_a = best_q; owa = own_q;
		fwd = '0; owd = '0;
		res_d = res_q;
		if (state_q == S_OSCAN && scan_done) begin
			if (mode_q == MODE_ALLOC) begin
				if (!own_found_q) res_d = '{ST_FULL, '0, '0};
				else              res_d = '{ST_NOFIT, '0, '0};
			end else begin
				res_d = '{ST_NOTFOUND, '0, '0};
			end
		end else if (state_q == S_COMMIT) begin
			if (mode_q == MODE_ALLOC) begin
				if (!best_found_q) begin
					res_d = '{ST_NOFIT, '0, '0};
				end else begin
					owe = 1'b1;
					owd = '{id_q, best_start_q, size_q};
					fwe = 1'b1;
					fwd.start = best_start_q + size_q[ADDR_W-1:0];
					fwd.len   = best_len_q - size_q;
					fclr = (best_len_q == size_q);
					res_d = '{ST_OK, best_start_q, size_q};
				end
			end else begin
				res_d = '{ST_OK, own_start_q, own_len_q};
				oclr  = 1'b1;
				priority if (lo_found_q) begin
					fwe = 1'b1; fwa = lo_q;
					fwd.start = lo_start_q;
					fwd.len = lo_len_q + own_len_q + (hi_found_q ? hi_len_q : '0);
					fclr = hi_found_q; fclr_a = hi_q;
				end else if (hi_found_q) begin
					fwe = 1'b1; fwa = hi_q;
					fwd = '{own_start_q, hi_len_q + own_len_q};
				end else if (spare_found_q) begin
					fwe = 1'b1; fwa = spare_q; fset = 1'b1;
					fwd = '{own_start_q, own_len_q};
				end else begin
					oclr  = 1'b0;
					res_d = '{ST_FULL, '0, '0};
				end
			end
		end
	end

	// Memory ports: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (fwe) fmem[fwa] <= fwd;
		if (owe) omem[owa] <= owd;
	end
	always_ff @(posedge clk) begin
		frd_q <= fmem[cnt_q[FIW-1:0]];
		ord_q <= omem[cnt_q[OIW-1:0]];
	end

	// Control registers and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fvalid_q    <= FREE_SLOTS'(1);
			ovalid_q    <= '0;
			f0_init_q   <= 1'b1;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (fwe && fwa == '0) f0_init_q <= 1'b0;
			if (fset) fvalid_q[fwa] <= 1'b1;
			if (fclr) fvalid_q[fclr_a] <= 1'b0;
			if (owe)  ovalid_q[owa] <= 1'b1;
			if (oclr) ovalid_q[own_q] <= 1'b0;
			if (state_q == S_RESP && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			// Scan address counter and the valid bit of the registered read.
			if (state_q != state_d) begin
				cnt_q <= '0;
				v_s1  <= 1'b0;
			end else if (state_q == S_OSCAN || state_q == S_FSCAN) begin
				v_s1 <= (cnt_q < lim);
				if (cnt_q < lim) cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Payload registers and scan bookkeeping.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[CW-2:0];
		res_q  <= res_d;
		if (state_q == S_RESP && (!out_valid_q || m_tready)) out_q <= res_q;
		if (state_q == S_IDLE) begin
			mode_q        <= mode_t'(s_tuser);
			id_q          <= s_tdata[7:0];
			size_q        <= s_tdata[18:8];
			own_found_q   <= 1'b0;
			best_found_q  <= 1'b0;
			lo_found_q    <= 1'b0;
			hi_found_q    <= 1'b0;
			spare_found_q <= 1'b0;
		end else if (state_q == S_OSCAN && v_s1 && !own_found_q) begin
			// Allocation wants the first idle slot, release the first match.
			if (mode_q == MODE_ALLOC && !ovalid_q[idx_s1[OIW-1:0]]) begin
				own_found_q <= 1'b1;
				own_q       <= idx_s1[OIW-1:0];
			end else if (mode_q == MODE_FREE && ovalid_q[idx_s1[OIW-1:0]] &&
				ord_q.tag == id_q) begin
				own_found_q <= 1'b1;
				own_q       <= idx_s1[OIW-1:0];
				own_start_q <= ord_q.start;
				own_len_q   <= ord_q.len;
			end
		end else if (state_q == S_FSCAN && v_s1) begin
			if (mode_q == MODE_ALLOC) begin
				// Smallest block that fits; the lowest slot wins a tie.
				if (fvalid_q[idx_s1[FIW-1:0]] && fent.len >= size_q &&
					(!best_found_q || fent.len < best_len_q)) begin
					best_found_q <= 1'b1;
					best_q       <= idx_s1[FIW-1:0];
					best_start_q <= fent.start;
					best_len_q   <= fent.len;
				end
			end else if (fvalid_q[idx_s1[FIW-1:0]]) begin
				// Neighbours in address below and above the released block.
				if (!lo_found_q && end_s1[LEN_W-1:0] == {1'b0, own_start_q}) begin
					lo_found_q <= 1'b1;
					lo_q       <= idx_s1[FIW-1:0];
					lo_start_q <= fent.start;
					lo_len_q   <= fent.len;
				end else if (!hi_found_q && {1'b0, fent.start} == own_end) begin
					hi_found_q <= 1'b1;
					hi_q       <= idx_s1[FIW-1:0];
					hi_len_q   <= fent.len;
				end
			end else if (!spare_found_q) begin
				spare_found_q <= 1'b1;
				spare_q       <= idx_s1[FIW-1:0];
			end
		end
	end

endmodule

[sim/testbench.sv]
// Self-checking testbench for the best-fit partition allocator unit.
`timescale 1ns / 100ps

module testbench;
	import bfpa_pkg::*;

	localparam int SLOTS      = 32;
	localparam int WDOG_LIMIT = 20000;
	localparam int SETTLE     = 200;

	// Predicts each allocator response and checks it against the unit.
	class alloc_scoreboard;
		int unsigned fr_start[SLOTS];
		int unsigned fr_len[SLOTS];
		bit          fr_vld[SLOTS];
		int unsigned own_tag[SLOTS];
		int unsigned own_start[SLOTS];
		int unsigned own_len[SLOTS];
		bit          own_vld[SLOTS];
		result_t     pending[$];
		int          errors;
		int          status_seen[4];

		function new();
			fr_len[0] = MEM_UNITS;
			fr_vld[0] = 1'b1;
		endfunction

		function result_t grant(int unsigned id, int unsigned size);
			result_t r;
			int slot, best;
			slot = -1;
			best = -1;
			r = '{status: ST_OK, start: '0, len: '0};
			for (int i = 0; i < SLOTS; i++) begin
				if (!own_vld[i] && slot < 0) begin
					slot = i;
				end
			end
			if (slot < 0) begin
				r.status = ST_FULL;
				return r;
			end
			if (size == 0) begin
				r.status = ST_NOFIT;
				return r;
			end
			// Smallest block that fits; the lowest slot wins a tie.
			for (int i = 0; i < SLOTS; i++) begin
				if (fr_vld[i] && fr_len[i] >= size && (best < 0 || fr_len[i] < fr_len[best])) begin
					best = i;
				end
			end
			if (best < 0) begin
				r.status = ST_NOFIT;
				return r;
			end
			own_tag[slot] = id;
			own_start[slot] = fr_start[best];
			own_len[slot] = size;
			own_vld[slot] = 1'b1;
			fr_start[best] += size;
			fr_len[best] -= size;
			if (fr_len[best] == 0) begin
				fr_vld[best] = 1'b0;
			end
			r.start = ADDR_W'(own_start[slot]);
			r.len = LEN_W'(size);
			return r;
		endfunction

		function result_t release_block(int unsigned id);
			result_t r;
			int own, lo, hi, spare;
			int unsigned s, e;
			own = -1;
			lo = -1;
			hi = -1;
			spare = -1;
			r = '{status: ST_OK, start: '0, len: '0};
			for (int i = 0; i < SLOTS; i++) begin
				if (own < 0 && own_vld[i] && own_tag[i] == id) begin
					own = i;
				end
			end
			if (own < 0) begin
				r.status = ST_NOTFOUND;
				return r;
			end
			s = own_start[own];
			e = s + own_len[own];
			// Find neighbours in address below and above, and a spare slot.
			for (int i = 0; i < SLOTS; i++) begin
				if (fr_vld[i]) begin
					if (lo < 0 && fr_start[i] + fr_len[i] == s) begin
						lo = i;
					end else if (hi < 0 && fr_start[i] == e) begin
						hi = i;
					end
				end else if (spare < 0) begin
					spare = i;
				end
			end
			if (lo < 0 && hi < 0) begin
				if (spare < 0) begin
					r.status = ST_FULL;
					return r;
				end
				fr_start[spare] = s;
				fr_len[spare] = own_len[own];
				fr_vld[spare] = 1'b1;
			end else if (lo >= 0) begin
				fr_len[lo] += own_len[own];
				if (hi >= 0) begin
					fr_len[lo] += fr_len[hi];
					fr_vld[hi] = 1'b0;
				end
			end else begin
				fr_start[hi] = s;
				fr_len[hi] += own_len[own];
			end
			own_vld[own] = 1'b0;
			r.start = ADDR_W'(s);
			r.len = LEN_W'(own_len[own]);
			return r;
		endfunction

		// Notes an accepted request and queues the response it must give.
		function void note_request(mode_t mode, logic [7:0] id, logic [10:0] size);
			if (mode == MODE_ALLOC) begin
				pending.push_back(grant(32'(id), 32'(size)));
			end else begin
				pending.push_back(release_block(32'(id)));
			end
		endfunction

		// Returns an id that currently holds a block, or a random one.
		function logic [7:0] held_id();
			int idx;
			idx = $urandom_range(SLOTS - 1);
			for (int i = 0; i < SLOTS; i++) begin
				if (own_vld[(idx + i) % SLOTS]) begin
					return 8'(own_tag[(idx + i) % SLOTS]);
				end
			end
			return 8'($urandom_range(255));
		endfunction

		function int owners_held();
			int n;
			n = 0;
			foreach (own_vld[i]) begin
				n += int'(own_vld[i]);
			end
			return n;
		endfunction

		task check_result(logic [23:0] data);
			result_t got, want;
			got.status = status_t'(data[1:0]);
			got.start = data[11:2];
			got.len = data[22:12];
			if (pending.size() == 0) begin
				report_mismatch($sformatf("response %h with none outstanding", data));
				return;
			end
			want = pending.pop_front();
			status_seen[got.status]++;
			if (got.status != want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.start != want.start)
				report_mismatch($sformatf("start %0d, want %0d", got.start, want.start));
			if (got.len != want.len)
				report_mismatch($sformatf("size %0d, want %0d", got.len, want.len));
			if (data[23] !== 1'b0)
				report_mismatch("padding bit set");
		endtask

		task report_mismatch(string msg);
			errors++;
			if (errors <= 50) begin
				$display("mismatch at %0t: %s", $realtime, msg);
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	alloc_scoreboard sb;
	int              burst_left;
	int              requests_sent;
	int              idle_cycles;

	best_fit_partition_allocator_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Presents one request and holds it until the transaction completes.
	task automatic send_request(mode_t mode, logic [7:0] id, logic [10:0] size);
		int gap;
		if (burst_left == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(20);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(12, 1);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {5'd0, size, id};
		do @(posedge clk); while (!s_tready);
		sb.note_request(mode, id, size);
		requests_sent++;
		burst_left--;
	endtask

	task automatic random_request();
		logic [10:0] size;
		int pick;
		pick = $urandom_range(99);
		if (pick < 55 || sb.owners_held() == 0 && pick < 90) begin
			pick = $urandom_range(99);
			if (pick < 70) size = 11'($urandom_range(32, 1));
			else if (pick < 94) size = 11'($urandom_range(300, 33));
			else if (pick < 99) size = 11'($urandom_range(1024, 301));
			else size = ($urandom_range(1) == 0) ? 11'd0 : 11'($urandom_range(2047, 1025));
			send_request(MODE_ALLOC, ($urandom_range(9) == 0) ? 8'($urandom_range(255))
				: 8'($urandom_range(31)), size);
		end else begin
			send_request(MODE_FREE, ($urandom_range(4) == 0) ? 8'($urandom_range(255))
				: sb.held_id(), 11'($urandom_range(2047)));
		end
	endtask

	// Receiver stalls on a slowly changing random pattern.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if ($urandom_range(7) == 0) begin
			m_tready <= ($urandom_range(2) != 0);
		end
	end

	// Response checking and the watchdog on stalled traffic.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles > WDOG_LIMIT) begin
				$display("watchdog expired with %0d responses outstanding", sb.pending.size());
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		burst_left = 0;
		requests_sent = 0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: whole pool, oversize, zero size, unknown owner,
		// duplicate ids and equal fits.
		send_request(MODE_ALLOC, 8'h00, 11'd1024);
		send_request(MODE_ALLOC, 8'hFF, 11'd1);
		send_request(MODE_FREE, 8'hFF, 11'd0);
		send_request(MODE_FREE, 8'h00, 11'd2047);
		send_request(MODE_FREE, 8'h00, 11'd0);
		send_request(MODE_ALLOC, 8'h01, 11'd0);
		send_request(MODE_ALLOC, 8'h02, 11'd2047);
		send_request(MODE_ALLOC, 8'h03, 11'd1025);
		send_request(MODE_ALLOC, 8'hAA, 11'd8);
		send_request(MODE_ALLOC, 8'hAA, 11'd8);
		send_request(MODE_ALLOC, 8'h55, 11'd8);
		send_request(MODE_ALLOC, 8'hAA, 11'd8);
		send_request(MODE_ALLOC, 8'h55, 11'd8);
		send_request(MODE_FREE, 8'hAA, 11'd0);
		send_request(MODE_FREE, 8'hAA, 11'd0);
		send_request(MODE_ALLOC, 8'h10, 11'd4);
		send_request(MODE_FREE, 8'h55, 11'd0);
		send_request(MODE_FREE, 8'h55, 11'd0);
		send_request(MODE_FREE, 8'hAA, 11'd0);
		send_request(MODE_FREE, 8'h10, 11'd0);
		send_request(MODE_ALLOC, 8'h7F, 11'd1000);
		send_request(MODE_ALLOC, 8'h80, 11'd24);
		send_request(MODE_FREE, 8'h7F, 11'd0);
		send_request(MODE_FREE, 8'h80, 11'd0);

		repeat (1830) random_request();
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("%0d requests: %0d ok, %0d no fit, %0d unknown owner, %0d table full",
			requests_sent, sb.status_seen[ST_OK], sb.status_seen[ST_NOFIT],
			sb.status_seen[ST_NOTFOUND], sb.status_seen[ST_FULL]);
		if (sb.errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
